/* rtl/crd_pkg.sv */
// Shared constants and types for the camera ray direction core.
package crd_pkg;

   localparam int unsigned COMPONENT_WIDTH = 21;
   localparam int unsigned POINT_FRAC_BITS = 16;
   localparam int unsigned POINT_WIDTH = POINT_FRAC_BITS + 1;
   localparam int unsigned REG_WIDTH = 3 * COMPONENT_WIDTH;
   localparam int unsigned DIR_WIDTH = 16;
   localparam int unsigned DIR_FRAC_BITS = 14;
   localparam int unsigned DIR_FRAC_MAX = 20;

   localparam int unsigned BASE_WIDTH = COMPONENT_WIDTH + 1;
   localparam int unsigned PROD_WIDTH = COMPONENT_WIDTH + POINT_WIDTH + 1;
   localparam int unsigned DIFF_WIDTH = COMPONENT_WIDTH + POINT_FRAC_BITS + 3;
   localparam int unsigned MAG_WIDTH = DIFF_WIDTH - 1;
   localparam int unsigned NORM_BITS = 30;
   localparam int unsigned SHIFT_STEPS = MAG_WIDTH - NORM_BITS;
   localparam int unsigned SHIFT_WIDTH = $clog2(SHIFT_STEPS + 1);
   localparam int unsigned SQUARE_WIDTH = 2 * NORM_BITS;
   localparam int unsigned SUM_WIDTH = SQUARE_WIDTH + 2;
   localparam int unsigned ROOT_WIDTH = SUM_WIDTH / 2;
   localparam int unsigned SAT_WIDTH = DIR_FRAC_MAX + 2;

   localparam int unsigned VECTOR_STAGES = 3;
   localparam int unsigned NORM_STAGES = 4;

   localparam logic [SAT_WIDTH-1:0] SAT_POS_MAX = SAT_WIDTH'(32767);
   localparam logic [SAT_WIDTH-1:0] SAT_NEG_MAX = SAT_WIDTH'(32768);
   localparam logic signed [DIR_WIDTH-1:0] DIR_MAX = 16'sh7FFF;
   localparam logic signed [DIR_WIDTH-1:0] DIR_MIN = 16'sh8000;

   typedef enum logic [1:0] {
      CSR_EYE_POSITION = 2'd0,
      CSR_LOWER_LEFT   = 2'd1,
      CSR_HORIZONTAL   = 2'd2,
      CSR_VERTICAL     = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [POINT_WIDTH-1:0] point_x;
      logic [POINT_WIDTH-1:0] point_y;
   } req_type;

   typedef struct packed {
      logic signed [DIR_WIDTH-1:0] dir_x;
      logic signed [DIR_WIDTH-1:0] dir_y;
      logic signed [DIR_WIDTH-1:0] dir_z;
      logic                        zero_length;
   } rsp_type;

   typedef struct packed {
      logic [2:0] neg;
      logic       zero;
   } flags_type;

   typedef struct packed {
      logic [2:0][NORM_BITS-1:0] e;
      flags_type                 flags;
   } carry_type;

endpackage

/* rtl/camera_ray_direction_core.sv */
// Pinhole camera primary ray direction core: unit ray direction for one view-plane point.
// Throughput: one request per cycle while busy is low, set by the fully pipelined root and divide stages.
// Requests pass the vector and normalize stages, the 31 root stages and DIR_FRAC_BITS + 1
// divide stages, then the result register, to rsp_valid; rsp_valid is one cycle.
// Reset clears all valid bits and the camera registers; busy is high only during reset.
module camera_ray_direction_core #(
   parameter int unsigned DIR_FRAC_BITS = crd_pkg::DIR_FRAC_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  crd_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   output crd_pkg::rsp_type                  rsp_data,
   input  logic                              csr_we,
   input  crd_pkg::csr_index_type            csr_index,
   input  logic [crd_pkg::REG_WIDTH-1:0]     csr_data
);

   localparam int unsigned LATENCY = crd_pkg::VECTOR_STAGES + crd_pkg::NORM_STAGES
                                   + crd_pkg::ROOT_WIDTH + DIR_FRAC_BITS + 3;

   logic [crd_pkg::REG_WIDTH-1:0]            eye_in;
   logic [crd_pkg::REG_WIDTH-1:0]            eye_ff;
   logic [crd_pkg::REG_WIDTH-1:0]            corner_in;
   logic [crd_pkg::REG_WIDTH-1:0]            corner_ff;
   logic [crd_pkg::REG_WIDTH-1:0]            hspan_in;
   logic [crd_pkg::REG_WIDTH-1:0]            hspan_ff;
   logic [crd_pkg::REG_WIDTH-1:0]            vspan_in;
   logic [crd_pkg::REG_WIDTH-1:0]            vspan_ff;
   logic                                     accept;
   logic                                     vec_valid;
   logic [2:0][crd_pkg::MAG_WIDTH-1:0]       vec_mag;
   logic [2:0]                               vec_neg;
   logic                                     norm_valid;
   logic [crd_pkg::SUM_WIDTH-1:0]            norm_sum;
   crd_pkg::carry_type                       norm_carry;
   logic                                     root_valid;
   logic [crd_pkg::ROOT_WIDTH-1:0]           root_value;
   crd_pkg::carry_type                       root_carry;

   assign busy   = reset;
   assign accept = start & ~busy;

   always_comb begin
      eye_in    = eye_ff;
      corner_in = corner_ff;
      hspan_in  = hspan_ff;
      vspan_in  = vspan_ff;
      if (csr_we) begin
         unique case (csr_index)
            crd_pkg::CSR_EYE_POSITION: eye_in    = csr_data;
            crd_pkg::CSR_LOWER_LEFT:   corner_in = csr_data;
            crd_pkg::CSR_HORIZONTAL:   hspan_in  = csr_data;
            crd_pkg::CSR_VERTICAL:     vspan_in  = csr_data;
            default:                   eye_in    = eye_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         eye_ff    <= '0;
         corner_ff <= '0;
         hspan_ff  <= '0;
         vspan_ff  <= '0;
      end else begin
         eye_ff    <= eye_in;
         corner_ff <= corner_in;
         hspan_ff  <= hspan_in;
         vspan_ff  <= vspan_in;
      end
   end

   crd_vector u_vector (
      .clock             (clock),
      .reset             (reset),
      .valid_in          (accept),
      .req_in            (req_data),
      .eye_position      (eye_ff),
      .lower_left_corner (corner_ff),
      .horizontal_span   (hspan_ff),
      .vertical_span     (vspan_ff),
      .valid_out         (vec_valid),
      .mag_out           (vec_mag),
      .neg_out           (vec_neg)
   );

   crd_norm u_norm (
      .clock     (clock),
      .reset     (reset),
      .valid_in  (vec_valid),
      .mag_in    (vec_mag),
      .neg_in    (vec_neg),
      .valid_out (norm_valid),
      .sum_out   (norm_sum),
      .carry_out (norm_carry)
   );

   crd_isqrt u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .valid_in  (norm_valid),
      .sum_in    (norm_sum),
      .carry_in  (norm_carry),
      .valid_out (root_valid),
      .root_out  (root_value),
      .carry_out (root_carry)
   );

   crd_div #(
      .DIR_FRAC_BITS (DIR_FRAC_BITS)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .valid_in  (root_valid),
      .root_in   (root_value),
      .carry_in  (root_carry),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   a_latency_fwd: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##LATENCY rsp_valid)
      else $error("request produced no response at the pipeline latency");

   a_latency_back: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, LATENCY))
      else $error("response without a matching request");

   a_nonzero_dir: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.zero_length |->
         (rsp_data.dir_x != '0) || (rsp_data.dir_y != '0) || (rsp_data.dir_z != '0))
      else $error("nonzero vector normalized to zero direction");

endmodule

/* rtl/crd_vector.sv */
// Direction vector stages: products, exact sum, sign and magnitude.
module crd_vector (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         valid_in,
   input  crd_pkg::req_type                             req_in,
   input  logic [crd_pkg::REG_WIDTH-1:0]                eye_position,
   input  logic [crd_pkg::REG_WIDTH-1:0]                lower_left_corner,
   input  logic [crd_pkg::REG_WIDTH-1:0]                horizontal_span,
   input  logic [crd_pkg::REG_WIDTH-1:0]                vertical_span,
   output logic                                         valid_out,
   output logic [2:0][crd_pkg::MAG_WIDTH-1:0]           mag_out,
   output logic [2:0]                                   neg_out
);

   localparam int unsigned CW = crd_pkg::COMPONENT_WIDTH;
   localparam int unsigned PF = crd_pkg::POINT_FRAC_BITS;
   localparam int unsigned BW = crd_pkg::BASE_WIDTH;
   localparam int unsigned PW = crd_pkg::PROD_WIDTH;
   localparam int unsigned DW = crd_pkg::DIFF_WIDTH;
   localparam int unsigned MW = crd_pkg::MAG_WIDTH;

   logic [crd_pkg::VECTOR_STAGES-1:0] valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[crd_pkg::VECTOR_STAGES-2:0], valid_in};
      end
   end

   assign valid_out = valid_ff[crd_pkg::VECTOR_STAGES-1];

   for (genvar k = 0; k < 3; k++) begin : g_lane
      logic [CW-1:0]        eye_c;
      logic [CW-1:0]        corner_c;
      logic [CW-1:0]        hspan_c;
      logic [CW-1:0]        vspan_c;
      logic signed [BW-1:0] base_in;
      logic signed [BW-1:0] base_ff;
      logic signed [PW-1:0] hprod_in;
      logic signed [PW-1:0] hprod_ff;
      logic signed [PW-1:0] vprod_in;
      logic signed [PW-1:0] vprod_ff;
      logic signed [DW-1:0] d_in;
      logic signed [DW-1:0] d_ff;
      logic [DW-1:0]        abs_c;
      logic [MW-1:0]        mag_ff;
      logic                 neg_ff;

      assign eye_c    = eye_position[k*CW +: CW];
      assign corner_c = lower_left_corner[k*CW +: CW];
      assign hspan_c  = horizontal_span[k*CW +: CW];
      assign vspan_c  = vertical_span[k*CW +: CW];

      assign base_in  = $signed({corner_c[CW-1], corner_c}) - $signed({eye_c[CW-1], eye_c});
      assign hprod_in = $signed(hspan_c) * $signed({1'b0, req_in.point_x});
      assign vprod_in = $signed(vspan_c) * $signed({1'b0, req_in.point_y});

      assign d_in = $signed({{(DW-BW-PF){base_ff[BW-1]}}, base_ff, {PF{1'b0}}})
                  + $signed({{(DW-PW){hprod_ff[PW-1]}}, hprod_ff})
                  + $signed({{(DW-PW){vprod_ff[PW-1]}}, vprod_ff});

      assign abs_c = d_ff[DW-1] ? (~d_ff + 1'b1) : d_ff;

      always_ff @(posedge clock) begin
         base_ff  <= base_in;
         hprod_ff <= hprod_in;
         vprod_ff <= vprod_in;
         d_ff     <= d_in;
         mag_ff   <= abs_c[MW-1:0];
         neg_ff   <= d_ff[DW-1];
      end

      assign mag_out[k] = mag_ff;
      assign neg_out[k] = neg_ff;
   end

endmodule

/* rtl/crd_norm.sv */
// Normalizing shift, squares and sum of squares.
module crd_norm (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                valid_in,
   input  logic [2:0][crd_pkg::MAG_WIDTH-1:0]  mag_in,
   input  logic [2:0]                          neg_in,
   output logic                                valid_out,
   output logic [crd_pkg::SUM_WIDTH-1:0]       sum_out,
   output crd_pkg::carry_type                  carry_out
);

   localparam int unsigned MW = crd_pkg::MAG_WIDTH;
   localparam int unsigned NB = crd_pkg::NORM_BITS;
   localparam int unsigned QS = crd_pkg::SQUARE_WIDTH;
   localparam int unsigned SW = crd_pkg::SUM_WIDTH;

   logic [crd_pkg::NORM_STAGES-1:0]   valid_ff;
   logic [MW-1:0]                     or_c;
   logic [crd_pkg::SHIFT_WIDTH-1:0]   shift_in;
   logic [crd_pkg::SHIFT_WIDTH-1:0]   shift_ff;
   logic [2:0][MW-1:0]                mag_ff;
   crd_pkg::flags_type                flags_in;
   crd_pkg::flags_type                flags_ff;
   crd_pkg::carry_type                scaled_in;
   crd_pkg::carry_type                scaled_ff;
   crd_pkg::carry_type                square_stage_ff;
   crd_pkg::carry_type                sum_stage_ff;
   logic [2:0][QS-1:0]                square_in;
   logic [2:0][QS-1:0]                square_ff;
   logic [SW-1:0]                     sum_in;
   logic [SW-1:0]                     sum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[crd_pkg::NORM_STAGES-2:0], valid_in};
      end
   end

   assign or_c = mag_in[0] | mag_in[1] | mag_in[2];

   always_comb begin
      shift_in = '0;
      for (int k = 0; k < crd_pkg::SHIFT_STEPS; k++) begin
         if (|(or_c >> (NB + k))) begin
            shift_in = shift_in + 1'b1;
         end
      end
   end

   assign flags_in.neg  = neg_in;
   assign flags_in.zero = ~|or_c;

   always_comb begin
      logic [MW-1:0] shifted;
      scaled_in.flags = flags_ff;
      for (int k = 0; k < 3; k++) begin
         shifted        = mag_ff[k] >> shift_ff;
         scaled_in.e[k] = shifted[NB-1:0];
      end
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         square_in[k] = scaled_ff.e[k] * scaled_ff.e[k];
      end
   end

   assign sum_in = {2'b00, square_ff[0]} + {2'b00, square_ff[1]} + {2'b00, square_ff[2]};

   always_ff @(posedge clock) begin
      mag_ff          <= mag_in;
      shift_ff        <= shift_in;
      flags_ff        <= flags_in;
      scaled_ff       <= scaled_in;
      square_ff       <= square_in;
      square_stage_ff <= scaled_ff;
      sum_ff          <= sum_in;
      sum_stage_ff    <= square_stage_ff;
   end

   assign valid_out = valid_ff[crd_pkg::NORM_STAGES-1];
   assign sum_out   = sum_ff;
   assign carry_out = sum_stage_ff;

endmodule

/* rtl/crd_isqrt.sv */
// Pipelined integer square root, one root bit per stage.
module crd_isqrt (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               valid_in,
   input  logic [crd_pkg::SUM_WIDTH-1:0]      sum_in,
   input  crd_pkg::carry_type                 carry_in,
   output logic                               valid_out,
   output logic [crd_pkg::ROOT_WIDTH-1:0]     root_out,
   output crd_pkg::carry_type                 carry_out
);

   localparam int unsigned RW = crd_pkg::ROOT_WIDTH;
   localparam int unsigned SW = crd_pkg::SUM_WIDTH;
   localparam int unsigned MW = RW + 2;
   localparam int unsigned TW = RW + 4;

   logic [RW-1:0]      valid_ff;
   logic [MW-1:0]      rem_in   [RW];
   logic [MW-1:0]      rem_ff   [RW];
   logic [RW-1:0]      root_in  [RW];
   logic [RW-1:0]      root_ff  [RW];
   logic [SW-1:0]      rest_in  [RW];
   logic [SW-1:0]      rest_ff  [RW];
   crd_pkg::carry_type carry_ff [RW];

   always_comb begin
      logic [MW-1:0] rem_p;
      logic [RW-1:0] root_p;
      logic [SW-1:0] rest_p;
      logic [TW-1:0] trial_c;
      logic [TW-1:0] test_c;
      logic [TW-1:0] diff_c;
      for (int i = 0; i < RW; i++) begin
         if (i == 0) begin
            rem_p  = '0;
            root_p = '0;
            rest_p = sum_in;
         end else begin
            rem_p  = rem_ff[i-1];
            root_p = root_ff[i-1];
            rest_p = rest_ff[i-1];
         end
         trial_c = {rem_p, rest_p[SW-1 -: 2]};
         test_c  = {2'b00, root_p, 2'b01};
         diff_c  = trial_c - test_c;
         if (trial_c >= test_c) begin
            rem_in[i]  = diff_c[MW-1:0];
            root_in[i] = {root_p[RW-2:0], 1'b1};
         end else begin
            rem_in[i]  = trial_c[MW-1:0];
            root_in[i] = {root_p[RW-2:0], 1'b0};
         end
         rest_in[i] = {rest_p[SW-3:0], 2'b00};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[RW-2:0], valid_in};
      end
   end

   always_ff @(posedge clock) begin
      carry_ff[0] <= carry_in;
      for (int i = 0; i < RW; i++) begin
         rem_ff[i]  <= rem_in[i];
         root_ff[i] <= root_in[i];
         rest_ff[i] <= rest_in[i];
      end
      for (int i = 1; i < RW; i++) begin
         carry_ff[i] <= carry_ff[i-1];
      end
   end

   assign valid_out = valid_ff[RW-1];
   assign root_out  = root_ff[RW-1];
   assign carry_out = carry_ff[RW-1];

endmodule

/* rtl/crd_div.sv */
// Pipelined rounding divide of three lanes by the root, saturation and result register.
module crd_div #(
   parameter int unsigned DIR_FRAC_BITS = crd_pkg::DIR_FRAC_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               valid_in,
   input  logic [crd_pkg::ROOT_WIDTH-1:0]     root_in,
   input  crd_pkg::carry_type                 carry_in,
   output logic                               rsp_valid,
   output crd_pkg::rsp_type                   rsp_data
);

   localparam int unsigned RW = crd_pkg::ROOT_WIDTH;
   localparam int unsigned NB = crd_pkg::NORM_BITS;
   localparam int unsigned QW = DIR_FRAC_BITS + 1;
   localparam int unsigned NW = NB + DIR_FRAC_BITS + 1;
   localparam int unsigned XW = crd_pkg::SAT_WIDTH;
   localparam int unsigned OW = crd_pkg::DIR_WIDTH;

   logic [QW:0]               valid_ff;
   logic [2:0][RW-1:0]        part_in  [QW+1];
   logic [2:0][RW-1:0]        part_ff  [QW+1];
   logic [2:0][QW-1:0]        low_in   [QW+1];
   logic [2:0][QW-1:0]        low_ff   [QW+1];
   logic [2:0][QW-1:0]        quo_in   [QW+1];
   logic [2:0][QW-1:0]        quo_ff   [QW+1];
   logic [RW-1:0]             div_ff   [QW+1];
   crd_pkg::flags_type        flags_ff [QW+1];
   logic signed [2:0][OW-1:0] dir_c;
   crd_pkg::rsp_type          rsp_in;
   crd_pkg::rsp_type          rsp_ff;
   logic                      rsp_valid_ff;

   always_comb begin
      logic [NW-1:0] num_c;
      logic [RW:0]   trial_c;
      logic [RW:0]   divisor_c;
      logic [RW:0]   diff_c;
      for (int k = 0; k < 3; k++) begin
         num_c = {1'b0, carry_in.e[k], {DIR_FRAC_BITS{1'b0}}}
               + {{(DIR_FRAC_BITS+1){1'b0}}, root_in[RW-1:1]};
         part_in[0][k] = {{(RW-NW+QW){1'b0}}, num_c[NW-1:QW]};
         low_in[0][k]  = num_c[QW-1:0];
         quo_in[0][k]  = '0;
      end
      for (int i = 1; i <= QW; i++) begin
         divisor_c = {1'b0, div_ff[i-1]};
         for (int k = 0; k < 3; k++) begin
            trial_c = {part_ff[i-1][k], low_ff[i-1][k][QW-1]};
            diff_c  = trial_c - divisor_c;
            if (trial_c >= divisor_c) begin
               part_in[i][k] = diff_c[RW-1:0];
               quo_in[i][k]  = {quo_ff[i-1][k][QW-2:0], 1'b1};
            end else begin
               part_in[i][k] = trial_c[RW-1:0];
               quo_in[i][k]  = {quo_ff[i-1][k][QW-2:0], 1'b0};
            end
            low_in[i][k] = {low_ff[i-1][k][QW-2:0], 1'b0};
         end
      end
   end

   always_comb begin
      logic [XW-1:0] q_c;
      logic [XW-1:0] neg_c;
      for (int k = 0; k < 3; k++) begin
         q_c   = {{(XW-QW){1'b0}}, quo_ff[QW][k]};
         neg_c = ~q_c + 1'b1;
         if (flags_ff[QW].zero) begin
            dir_c[k] = '0;
         end else if (flags_ff[QW].neg[k]) begin
            dir_c[k] = (q_c > crd_pkg::SAT_NEG_MAX) ? crd_pkg::DIR_MIN : neg_c[OW-1:0];
         end else begin
            dir_c[k] = (q_c > crd_pkg::SAT_POS_MAX) ? crd_pkg::DIR_MAX : q_c[OW-1:0];
         end
      end
      rsp_in.dir_x       = dir_c[0];
      rsp_in.dir_y       = dir_c[1];
      rsp_in.dir_z       = dir_c[2];
      rsp_in.zero_length = flags_ff[QW].zero;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= {valid_ff[QW-1:0], valid_in};
         rsp_valid_ff <= valid_ff[QW];
      end
   end

   always_ff @(posedge clock) begin
      div_ff[0]   <= root_in;
      flags_ff[0] <= carry_in.flags;
      for (int i = 0; i <= QW; i++) begin
         part_ff[i] <= part_in[i];
         low_ff[i]  <= low_in[i];
         quo_ff[i]  <= quo_in[i];
      end
      for (int i = 1; i <= QW; i++) begin
         div_ff[i]   <= div_ff[i-1];
         flags_ff[i] <= flags_ff[i-1];
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
